[hw/rtl/fifoed_pkg.sv]
// Shared types and codes for the editable FIFO.
// No dependencies; used by the cell row, the top level and the checker.
package fifoed_pkg;

  // Wide enough for any cell index or count up to the largest depth (256).
  localparam int IDX_W = 9;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_EDIT   = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic             shift_en;   // cells at or above shift_from take their upper neighbour
    logic [IDX_W-1:0] shift_from;
    logic             wr_en;      // cell wr_idx loads the request word
    logic [IDX_W-1:0] wr_idx;
  } cell_cmd_t;

endpackage

[hw/rtl/fifo_with_edit_and_delete_unit.sv]
// Top level of the editable FIFO: request decode, entry count, result register
// and the row of fifoed_cell instances. Depends on fifoed_pkg and fifoed_cell.
//
//   channel | direction | fields                                  | handshake
//   in_     | input     | operation, position, payload            | in_valid / in_ready
//   out_    | output    | status, popped_word, occupancy          | out_valid / out_ready
//
// One request per cycle while no result is stalled; its result is registered and shows the cycle after.
// Every cell updates in the same cycle, so pop shifts the whole row and delete
// every cell from the position up at once; the count compare and the cell index compare set the path length.
// Reset (rst_n low, synchronous) empties the queue and drops a pending result.
// While a result waits, in_ready follows out_ready; a stalled result holds.
module fifo_with_edit_and_delete_unit
  import fifoed_pkg::*;
#(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_position,
  input  logic [63:0] in_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_popped_word,
  output logic [4:0]  out_occupancy
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic [63:0]      popped_r, popped_nxt;
  logic [4:0]       occ_r;

  logic                    accept;
  op_t                     op;
  logic [IDX_W-1:0]        pos_ext;
  logic [IDX_W-1:0]        cnt_ext;
  logic                    pos_ok;
  cell_cmd_t               cmd;
  logic [PAYLOAD_BITS-1:0] wr_word;
  logic [PAYLOAD_BITS-1:0] cell_word [DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign op       = op_t'(in_operation);
  assign pos_ext  = IDX_W'(in_position);
  assign cnt_ext  = IDX_W'(count_r);
  assign pos_ok   = pos_ext < cnt_ext;
  assign wr_word  = in_payload[PAYLOAD_BITS-1:0];

  always_comb begin
    cmd        = '0;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    popped_nxt = '0;
    unique case (op)
      OP_PUSH: begin
        if (count_r == CNT_W'(DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.wr_en  = accept;
          cmd.wr_idx = cnt_ext;
          count_nxt  = count_r + 1'b1;
        end
      end
      OP_POP: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          popped_nxt     = 64'(cell_word[0]);
          cmd.shift_en   = accept;
          cmd.shift_from = '0;
          count_nxt      = count_r - 1'b1;
        end
      end
      OP_EDIT: begin
        if (!pos_ok) begin
          status_nxt = ST_BADPOS;
        end else begin
          cmd.wr_en  = accept;
          cmd.wr_idx = pos_ext;
        end
      end
      OP_DELETE: begin
        if (!pos_ok) begin
          status_nxt = ST_BADPOS;
        end else begin
          cmd.shift_en   = accept;
          cmd.shift_from = pos_ext;
          count_nxt      = count_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [PAYLOAD_BITS-1:0] upper;
    if (g == DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = cell_word[g+1];
    end
    fifoed_cell #(
      .IDX          (g),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .wr_word    (wr_word),
      .upper_word (upper),
      .word       (cell_word[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      popped_r <= popped_nxt;
      occ_r    <= 5'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_popped_word = popped_r;
  assign out_occupancy   = occ_r;

endmodule

[hw/rtl/fifoed_cell.sv]
// One storage cell of the queue row: holds a word, loads it, or takes its
// upper neighbour's word when the row closes a gap. Depends on fifoed_pkg.
module fifoed_cell
  import fifoed_pkg::*;
#(
  parameter int IDX          = 0,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                    clk,
  input  cell_cmd_t               cmd,
  input  logic [PAYLOAD_BITS-1:0] wr_word,
  input  logic [PAYLOAD_BITS-1:0] upper_word,
  output logic [PAYLOAD_BITS-1:0] word
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [PAYLOAD_BITS-1:0] data_r;
  logic [PAYLOAD_BITS-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.wr_en && (cmd.wr_idx == MY_IDX)) begin
      data_nxt = wr_word;
    end else if (cmd.shift_en && (MY_IDX >= cmd.shift_from)) begin
      data_nxt = upper_word;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign word = data_r;

endmodule

[hw/rtl/fifoed_chk.sv]
// Port-level checker for the editable FIFO, bound to the top level.
// Depends on fifoed_pkg.
module fifoed_chk
  import fifoed_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [63:0] out_popped_word,
  input logic [4:0]  out_occupancy
);

  localparam logic [4:0] FULL_OCC = 5'(DEPTH);

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_popped_word) && $stable(out_occupancy))
    else $error("result changed while stalled");

  // An empty report only when nothing is left.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> out_occupancy == 5'd0)
    else $error("empty status with entries present");

  // A full report only when the queue is at capacity.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_occupancy == FULL_OCC)
    else $error("full status below capacity");

  // A request that failed hands back no word.
  a_popzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_popped_word == 64'd0)
    else $error("word returned on a failed request");

  // No request taken while a result is stalled.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

endmodule

bind fifo_with_edit_and_delete_unit fifoed_chk #(.DEPTH(DEPTH)) u_fifoed_chk (.*);
